// ----- rtl/core/multichannel_conv2d_stride_pad_assert.svh -----
// ----------------------------------------------------------------------------
// multichannel_conv2d_stride_pad_assert.svh
// Assertion macros used by the convolution engine checker.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_CONV2D_STRIDE_PAD_ASSERT_SVH
`define MULTICHANNEL_CONV2D_STRIDE_PAD_ASSERT_SVH

// same-cycle implication
`define MCSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MCSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/mcsp_pkg.sv -----
// ----------------------------------------------------------------------------
// mcsp_pkg
// Types, codes and limits of the multichannel convolution engine.
// ----------------------------------------------------------------------------
package mcsp_pkg;

	localparam int DEF_MAX_WIDTH    = 32;
	localparam int DEF_MAX_HEIGHT   = 32;
	localparam int DEF_MAX_CHANNELS = 8;
	localparam int DEF_MAX_KERNEL   = 8;

	typedef enum logic [1:0] {
		REQ_WEIGHT  = 2'd0,
		REQ_SAMPLE  = 2'd1,
		REQ_COMPUTE = 2'd2
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_GEOMETRY = 2'd1,
		ST_RANGE    = 2'd2
	} status_code_t;

	typedef enum logic [2:0] {
		REG_IN_WIDTH  = 3'd0,
		REG_IN_HEIGHT = 3'd1,
		REG_CHANNELS  = 3'd2,
		REG_KWIDTH    = 3'd3,
		REG_KHEIGHT   = 3'd4,
		REG_STEP      = 3'd5,
		REG_PAD       = 3'd6,
		REG_BIAS      = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [5:0]         pos_x;
		logic [5:0]         pos_y;
		logic [2:0]         chan;
		logic signed [15:0] sample_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] conv_sum;
		status_code_t       status;
	} res_t;

	typedef struct packed {
		logic load_accept;
		logic start;
		logic div_run;
		logic check;
		logic issue;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic         div_done;
		status_code_t code;
		logic         last;
		logic         busy;
	} sts_t;

endpackage

// ----- rtl/core/multichannel_conv2d_stride_pad.sv -----
// ----------------------------------------------------------------------------
// multichannel_conv2d_stride_pad
// Multichannel 2-D convolution with stride and zero padding, Q8.8 data.
//
// Channels: req (valid/stall) takes weight loads, sample loads and compute
// requests; res (valid/stall) returns one item per compute request; cfg
// (valid/ready, always ready) writes the shape and bias registers; the user
// must write them only while idle; the block does not enforce it. Loads give
// no result item. A compute request runs the stride remainder iteration, a
// geometry check, then the tap loop over channel_count * kernel_height *
// kernel_width taps (512 at most at default limits), a drain of the read and
// multiply registers and a handoff to the output register. The tap loop runs
// one multiply-accumulate a cycle from one read port of each store. Requests
// with bad geometry or an out-of-range position skip the tap loop.
// The result sits in an output register; the block takes new loads while it
// waits, and a second compute finishes only once the register is free.
// Reset restores the default shape; store contents stay undefined until
// loaded, and no clearing pass runs.
// ----------------------------------------------------------------------------
module multichannel_conv2d_stride_pad import mcsp_pkg::*; #(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
	parameter int MAX_KERNEL   = DEF_MAX_KERNEL
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	mcsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.req_stall (req_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	mcsp_datapath #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.MAX_CHANNELS (MAX_CHANNELS),
		.MAX_KERNEL   (MAX_KERNEL)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.res       (res)
	);

endmodule

// ----- rtl/core/mcsp_ctrl.sv -----
// ----------------------------------------------------------------------------
// mcsp_ctrl
// Sequencer: request intake, stride remainder iteration, geometry check, MAC sweep, result handoff.
// ----------------------------------------------------------------------------
module mcsp_ctrl import mcsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_type,
	output logic       req_stall,
	output logic       res_valid,
	input  logic       res_stall,
	output cmd_t       cmd,
	input  sts_t       sts
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_DIV   = 6'b000010,
		S_CHECK = 6'b000100,
		S_MAC   = 6'b001000,
		S_DRAIN = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   res_valid_q;
	logic   out_free;

	assign out_free  = !res_valid_q || !res_stall;
	assign req_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_accept = 1'b1;
					if (req_type == REQ_COMPUTE) begin
						cmd.start = 1'b1;
						state_d   = S_DIV;
					end
				end
			end
			S_DIV: begin
				cmd.div_run = 1'b1;
				if (sts.div_done) state_d = S_CHECK;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = (sts.code == ST_OK) ? S_MAC : S_DONE;
			end
			S_MAC: begin
				cmd.issue = 1'b1;
				if (sts.last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!sts.busy) state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/core/mcsp_datapath.sv -----
// ----------------------------------------------------------------------------
// mcsp_datapath
// Shape registers, sample and weight stores, stride remainder unit, tap address
// generation, the multiply-accumulate pipe and the result register.
// ----------------------------------------------------------------------------
module mcsp_datapath import mcsp_pkg::*; #(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
	parameter int MAX_KERNEL   = DEF_MAX_KERNEL
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  req_t        req,
	input  cmd_t        cmd,
	output sts_t        sts,
	output res_t        res
);

	localparam int SAMPLE_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
	localparam int WEIGHT_DEPTH = MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS;
	localparam int SA_W  = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
	localparam int WA_W  = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
	localparam int ACC_W = 34 + WA_W;
	localparam int DIV_BITS = 7;

	// shape registers
	logic [5:0]  in_width_q, in_height_q;
	logic [3:0]  ch_q, kw_q, kh_q, step_q;
	logic [2:0]  pad_q;
	logic [31:0] bias_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q  <= 6'd28;
			in_height_q <= 6'd28;
			ch_q        <= 4'd1;
			kw_q        <= 4'd5;
			kh_q        <= 4'd5;
			step_q      <= 4'd1;
			pad_q       <= 3'd0;
			bias_q      <= 32'd0;
		end else if (cfg_valid) begin
			case (reg_index_t'(cfg_index))
				REG_IN_WIDTH:  in_width_q  <= cfg_data[5:0];
				REG_IN_HEIGHT: in_height_q <= cfg_data[5:0];
				REG_CHANNELS:  ch_q        <= cfg_data[3:0];
				REG_KWIDTH:    kw_q        <= cfg_data[3:0];
				REG_KHEIGHT:   kh_q        <= cfg_data[3:0];
				REG_STEP:      step_q      <= cfg_data[3:0];
				REG_PAD:       pad_q       <= cfg_data[2:0];
				REG_BIAS:      bias_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// loads
	logic            wt_wr, smp_wr;
	logic [SA_W-1:0] smp_waddr;
	logic [WA_W-1:0] wt_waddr;

	assign wt_wr = cmd.load_accept && (req.req_type == REQ_WEIGHT) &&
		({2'b0, req.pos_x} < {4'b0, kw_q}) && (32'(req.pos_x) < MAX_KERNEL) &&
		({2'b0, req.pos_y} < {4'b0, kh_q}) && (32'(req.pos_y) < MAX_KERNEL) &&
		({1'b0, req.chan} < ch_q) && (32'(req.chan) < MAX_CHANNELS);
	assign smp_wr = cmd.load_accept && (req.req_type == REQ_SAMPLE) &&
		(req.pos_x < in_width_q) && (32'(req.pos_x) < MAX_WIDTH) &&
		(req.pos_y < in_height_q) && (32'(req.pos_y) < MAX_HEIGHT) &&
		({1'b0, req.chan} < ch_q) && (32'(req.chan) < MAX_CHANNELS);

	assign wt_waddr = WA_W'(32'(req.pos_x) + 32'(req.pos_y) * MAX_KERNEL +
		32'(req.chan) * (MAX_KERNEL * MAX_KERNEL));
	assign smp_waddr = SA_W'(32'(req.pos_x) + 32'(req.pos_y) * MAX_WIDTH +
		32'(req.chan) * (MAX_WIDTH * MAX_HEIGHT));

	// geometry: numerators and their remainders modulo the stride
	logic signed [7:0] nw, nh;
	logic              geom_ok;

	assign nw = $signed({2'b0, in_width_q}) - $signed({4'b0, kw_q}) +
		$signed({4'b0, pad_q, 1'b0});
	assign nh = $signed({2'b0, in_height_q}) - $signed({4'b0, kh_q}) +
		$signed({4'b0, pad_q, 1'b0});
	assign geom_ok = (in_width_q != 6'd0) && (32'(in_width_q) <= MAX_WIDTH) &&
		(in_height_q != 6'd0) && (32'(in_height_q) <= MAX_HEIGHT) &&
		(ch_q != 4'd0) && (32'(ch_q) <= MAX_CHANNELS) &&
		(kw_q != 4'd0) && (32'(kw_q) <= MAX_KERNEL) &&
		(kh_q != 4'd0) && (32'(kh_q) <= MAX_KERNEL) &&
		(step_q != 4'd0);

	logic [5:0] px_q, py_q;
	logic [2:0] div_cnt_q;
	logic [3:0] rem_w_q, rem_h_q;
	logic [4:0] sh_w, sh_h;
	logic [9:0] pxs_q, pys_q;

	assign sh_w = {rem_w_q, nw[div_cnt_q]};
	assign sh_h = {rem_h_q, nh[div_cnt_q]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.start) begin
			div_cnt_q <= 3'(DIV_BITS - 1);
		end else if (cmd.div_run && div_cnt_q != 3'd0) begin
			div_cnt_q <= div_cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			px_q    <= req.pos_x;
			py_q    <= req.pos_y;
			rem_w_q <= 4'd0;
			rem_h_q <= 4'd0;
		end else if (cmd.div_run) begin
			rem_w_q <= (sh_w >= {1'b0, step_q}) ? 4'(sh_w - {1'b0, step_q}) : 4'(sh_w);
			rem_h_q <= (sh_h >= {1'b0, step_q}) ? 4'(sh_h - {1'b0, step_q}) : 4'(sh_h);
		end
		pxs_q <= px_q * step_q;
		pys_q <= py_q * step_q;
	end

	status_code_t code;
	always_comb begin
		if (!geom_ok || nw[7] || nh[7] || rem_w_q != 4'd0 || rem_h_q != 4'd0)
			code = ST_GEOMETRY;
		else if (pxs_q > {3'b0, nw[6:0]} || pys_q > {3'b0, nh[6:0]})
			code = ST_RANGE;
		else
			code = ST_OK;
	end

	// tap counters, channel outermost
	logic [3:0] c_q, fy_q, fx_q;
	logic       fx_end, fy_end, c_end;

	assign fx_end = (fx_q == kw_q - 4'd1);
	assign fy_end = (fy_q == kh_q - 4'd1);
	assign c_end  = (c_q == ch_q - 4'd1);

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			c_q  <= 4'd0;
			fy_q <= 4'd0;
			fx_q <= 4'd0;
		end else if (cmd.issue) begin
			if (fx_end) begin
				fx_q <= 4'd0;
				if (fy_end) begin
					fy_q <= 4'd0;
					c_q  <= c_q + 4'd1;
				end else begin
					fy_q <= fy_q + 4'd1;
				end
			end else begin
				fx_q <= fx_q + 4'd1;
			end
		end
	end

	logic signed [11:0] ix, iy;
	logic               in_image;
	logic [SA_W-1:0]    smp_raddr;
	logic [WA_W-1:0]    wt_raddr;

	assign ix = $signed({2'b0, pxs_q}) + $signed({8'b0, fx_q}) - $signed({9'b0, pad_q});
	assign iy = $signed({2'b0, pys_q}) + $signed({8'b0, fy_q}) - $signed({9'b0, pad_q});
	assign in_image = !ix[11] && (ix[10:0] < {5'b0, in_width_q}) &&
		!iy[11] && (iy[10:0] < {5'b0, in_height_q});
	assign smp_raddr = SA_W'(32'(ix[5:0]) + 32'(iy[5:0]) * MAX_WIDTH +
		32'(c_q) * (MAX_WIDTH * MAX_HEIGHT));
	assign wt_raddr = WA_W'(32'(fx_q) + 32'(fy_q) * MAX_KERNEL +
		32'(c_q) * (MAX_KERNEL * MAX_KERNEL));

	// stores
	logic signed [15:0] sample_mem [SAMPLE_DEPTH];
	logic signed [15:0] weight_mem [WEIGHT_DEPTH];
	logic signed [15:0] smp_s1, wt_s1;

	always_ff @(posedge clk) begin
		if (smp_wr) sample_mem[smp_waddr] <= req.sample_value;
		if (cmd.issue) smp_s1 <= sample_mem[smp_raddr];
	end

	always_ff @(posedge clk) begin
		if (wt_wr) weight_mem[wt_waddr] <= req.sample_value;
		if (cmd.issue) wt_s1 <= weight_mem[wt_raddr];
	end

	// multiply and accumulate
	logic               v_s1, v_s2;
	logic signed [31:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	status_code_t       status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue && in_image;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= smp_s1 * wt_s1;
		if (cmd.check) begin
			acc_q    <= {{(ACC_W - 32){bias_q[31]}}, bias_q};
			status_q <= code;
		end else if (v_s2) begin
			acc_q <= acc_q + {{(ACC_W - 32){prod_s2[31]}}, prod_s2};
		end
	end

	logic signed [31:0] sat_sum;
	always_comb begin
		if (acc_q > $signed({{(ACC_W - 32){1'b0}}, 32'h7fff_ffff}))
			sat_sum = 32'sh7fff_ffff;
		else if (acc_q < $signed({{(ACC_W - 32){1'b1}}, 32'h8000_0000}))
			sat_sum = 32'sh8000_0000;
		else
			sat_sum = acc_q[31:0];
	end

	res_t res_q;
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_q.conv_sum <= (status_q == ST_OK) ? sat_sum : 32'sd0;
			res_q.status   <= status_q;
		end
	end

	assign res = res_q;

	assign sts.div_done = (div_cnt_q == 3'd0);
	assign sts.code     = code;
	assign sts.last     = fx_end && fy_end && c_end;
	assign sts.busy     = v_s1 || v_s2;

endmodule

// ----- rtl/core/mcsp_checker.sv -----
// ----------------------------------------------------------------------------
// mcsp_checker
// Port-level checks of the convolution engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "multichannel_conv2d_stride_pad_assert.svh"

module mcsp_checker import mcsp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	`MCSP_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid, "result item dropped while stalled")
	`MCSP_ASSERT_IMPLY(a_err_zero, clk, arst_n, res_valid && res.status != ST_OK, res.conv_sum == 32'sd0, "error result with nonzero sum")
	`MCSP_ASSERT_NEXT(a_compute_busy, clk, arst_n, req_valid && !req_stall && req.req_type == REQ_COMPUTE, req_stall, "compute did not block intake")
	`MCSP_ASSERT_NEXT(a_load_fast, clk, arst_n, req_valid && !req_stall && req.req_type != REQ_COMPUTE, !req_stall, "load blocked intake")

endmodule

bind multichannel_conv2d_stride_pad mcsp_checker u_mcsp_checker (.*);
